/* rtl/core/vad_pkg.sv */
// ----------------------------------------------------------------------------
// Voice activity detector package
// Shared widths, constants, register indexes, controller states and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package vad_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int AMP_W         = 25;
  localparam int RATIO_W       = 16;
  localparam int QUIET_W       = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 25;
  localparam int FRAC_SH       = 2 * (AMP_W - SAMPLE_BITS);
  localparam int SQ_W          = 2 * SAMPLE_BITS - 1;
  localparam int MAX_BLOCK_DEF = 1024;
  localparam int COEF_W        = 13;
  localparam int COEF_SH       = 16;
  localparam int RMS_SH        = 12;
  localparam int PROD_W        = AMP_W + RATIO_W;
  localparam int STEP_PROD_W   = AMP_W + COEF_W;
  localparam int STEP_W        = STEP_PROD_W - COEF_SH;
  localparam int RAD_W         = 2 * AMP_W;
  localparam int SQRT_CNT_W    = $clog2(AMP_W);

  localparam logic [AMP_W-1:0]   FLOOR_RESET = AMP_W'(1678);
  localparam logic [AMP_W-1:0]   FLOOR_MIN   = AMP_W'(168);
  localparam logic [COEF_W-1:0]  RISE_COEF   = COEF_W'(1311);
  localparam logic [COEF_W-1:0]  FALL_COEF   = COEF_W'(6554);
  localparam logic [QUIET_W-1:0] QUIET_MAX   = {QUIET_W{1'b1}};

  localparam logic [RATIO_W-1:0] ONSET_RATIO_RST   = RATIO_W'(12288);
  localparam logic [RATIO_W-1:0] RELEASE_RATIO_RST = RATIO_W'(6144);
  localparam logic [AMP_W-1:0]   MIN_ONSET_RST     = AMP_W'(167772);
  localparam logic [QUIET_W-1:0] MIN_GAP_RST       = QUIET_W'(12000);
  localparam logic [QUIET_W-1:0] INIT_QUIET_RST    = QUIET_W'(480000);

  localparam logic [CFG_IDX_W-1:0] REG_ONSET_RATIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ONSET_RMS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_QUIET    = 3'd4;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_DECIDE,
    ST_STEP,
    ST_UPDATE,
    ST_EMIT
  } vad_state_t;

  typedef struct packed {
    logic acc;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic mul;
    logic decide;
    logic step_mul;
    logic update;
    logic emit;
  } vad_cmd_t;

  typedef struct packed {
    logic close;
    logic div_last;
    logic sqrt_last;
    logic out_busy;
  } vad_sts_t;

endpackage

/* rtl/core/vad_in_if.sv */
// ----------------------------------------------------------------------------
// Voice activity detector sample channel
// Valid/ready channel carrying one audio sample and its last-of-block flag.
// ----------------------------------------------------------------------------
interface vad_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vad_pkg::SAMPLE_BITS-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/vad_out_if.sv */
// ----------------------------------------------------------------------------
// Voice activity detector result channel
// Valid/ready channel carrying one per-block result word.
// ----------------------------------------------------------------------------
interface vad_out_if;
  logic                      valid;
  logic                      ready;
  logic [vad_pkg::AMP_W-1:0] rms;
  logic [vad_pkg::AMP_W-1:0] noise_floor;
  logic                      voiced;
  logic                      word_onset;

  modport source (output valid, output rms, output noise_floor, output voiced,
                  output word_onset, input ready);
  modport sink   (input valid, input rms, input noise_floor, input voiced,
                  input word_onset, output ready);
endinterface

/* rtl/core/vad_ctrl.sv */
// ----------------------------------------------------------------------------
// Voice activity detector controller
// Sequences sample accumulation, the block-end divide and square root, the
// threshold decision, the floor update and the result hand-off.
// ----------------------------------------------------------------------------
module vad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vad_pkg::vad_sts_t sts,
  output vad_pkg::vad_cmd_t cmd
);

  vad_pkg::vad_state_t state_r;
  vad_pkg::vad_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vad_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vad_pkg::ST_ACC: begin
        if (in_valid && sts.close) state_nxt = vad_pkg::ST_DIV;
      end
      vad_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = vad_pkg::ST_SQRT_LOAD;
      end
      vad_pkg::ST_SQRT_LOAD: state_nxt = vad_pkg::ST_SQRT;
      vad_pkg::ST_SQRT: begin
        if (sts.sqrt_last) state_nxt = vad_pkg::ST_MUL;
      end
      vad_pkg::ST_MUL:    state_nxt = vad_pkg::ST_DECIDE;
      vad_pkg::ST_DECIDE: state_nxt = vad_pkg::ST_STEP;
      vad_pkg::ST_STEP:   state_nxt = vad_pkg::ST_UPDATE;
      vad_pkg::ST_UPDATE: state_nxt = vad_pkg::ST_EMIT;
      vad_pkg::ST_EMIT: begin
        if (!sts.out_busy) state_nxt = vad_pkg::ST_ACC;
      end
      default: state_nxt = vad_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vad_pkg::ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
      end
      vad_pkg::ST_DIV:       cmd.div_step  = 1'b1;
      vad_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
      vad_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
      vad_pkg::ST_MUL:       cmd.mul       = 1'b1;
      vad_pkg::ST_DECIDE:    cmd.decide    = 1'b1;
      vad_pkg::ST_STEP:      cmd.step_mul  = 1'b1;
      vad_pkg::ST_UPDATE:    cmd.update    = 1'b1;
      vad_pkg::ST_EMIT:      cmd.emit      = !sts.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/vad_datapath.sv */
// ----------------------------------------------------------------------------
// Voice activity detector datapath
// Square accumulator, bit-serial divider, digit-serial square root,
// threshold products, noise floor tracker, configuration and result register.
// ----------------------------------------------------------------------------
module vad_datapath #(
  parameter int MAX_BLOCK = vad_pkg::MAX_BLOCK_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic signed [vad_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  input  vad_pkg::vad_cmd_t                      cmd,
  output vad_pkg::vad_sts_t                      sts,
  input  logic                                   cfg_wr_en,
  input  logic [vad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vad_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [vad_pkg::AMP_W-1:0]              out_rms,
  output logic [vad_pkg::AMP_W-1:0]              out_noise_floor,
  output logic                                   out_voiced,
  output logic                                   out_word_onset
);

  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W     = vad_pkg::SQ_W - 1 + CNT_W;
  localparam int DVD_W     = SUM_W + vad_pkg::FRAC_SH;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int AMP_W     = vad_pkg::AMP_W;
  localparam int QUIET_W   = vad_pkg::QUIET_W;
  localparam int SB        = vad_pkg::SAMPLE_BITS;

  // Configuration registers.
  logic [vad_pkg::RATIO_W-1:0] onset_ratio_r;
  logic [vad_pkg::RATIO_W-1:0] release_ratio_r;
  logic [AMP_W-1:0]            min_onset_r;
  logic [QUIET_W-1:0]          min_gap_r;

  // Block accumulator.
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SB-1:0]    mag;
  logic [2*SB-1:0]  sq;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] cnt_nxt;

  // Divider.
  logic [DVD_W-1:0]     dq_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     n_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       div_t;
  logic                 div_ge;

  // Square root.
  logic [vad_pkg::RAD_W-1:0]      rad_r;
  logic [AMP_W+1:0]               srem_r;
  logic [AMP_W-1:0]               root_r;
  logic [vad_pkg::SQRT_CNT_W-1:0] sqrt_cnt_r;
  logic [AMP_W+1:0]               sq_t;
  logic [AMP_W+1:0]               sq_trial;
  logic                           sq_ge;

  // Decision and floor tracking.
  logic [vad_pkg::PROD_W-1:0]      prod_on_r;
  logic [vad_pkg::PROD_W-1:0]      prod_rel_r;
  logic [vad_pkg::PROD_W-1:0]      rms_scaled;
  logic [QUIET_W:0]                quiet_sum;
  logic [QUIET_W-1:0]              quiet_sat;
  logic                            start_voice;
  logic [AMP_W-1:0]                floor_r;
  logic                            voice_r;
  logic [QUIET_W-1:0]              quiet_r;
  logic                            onset_r;
  logic                            adapt_r;
  logic                            rise_r;
  logic [AMP_W-1:0]                diff_r;
  logic [vad_pkg::STEP_W-1:0]      step_r;
  logic [vad_pkg::STEP_PROD_W-1:0] step_prod;
  logic [AMP_W:0]                  floor_moved;
  logic [AMP_W-1:0]                floor_nxt;

  logic out_valid_r;

  // Sample magnitude and running sums.
  always_comb begin
    mag     = sample[SB-1] ? (~sample + 1'b1) : sample;
    sq      = mag * mag;
    sum_nxt = sum_r + SUM_W'(sq[vad_pkg::SQ_W-1:0]);
    cnt_nxt = cnt_r + 1'b1;
  end

  assign sts.close     = last || (cnt_nxt == CNT_W'(MAX_BLOCK));
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(DVD_W - 1));
  assign sts.sqrt_last = (sqrt_cnt_r == vad_pkg::SQRT_CNT_W'(AMP_W - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      if (sts.close) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Restoring divide of the scaled sum by the sample count, one bit a cycle.
  always_comb begin
    div_t  = {rem_r, dq_r[DVD_W-1]};
    div_ge = (div_t >= {1'b0, n_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && sts.close) begin
      dq_r      <= {sum_nxt, {vad_pkg::FRAC_SH{1'b0}}};
      rem_r     <= '0;
      n_r       <= cnt_nxt;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= div_ge ? CNT_W'(div_t - {1'b0, n_r}) : div_t[CNT_W-1:0];
      dq_r      <= {dq_r[DVD_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Digit-by-digit square root, one root bit a cycle.
  always_comb begin
    sq_t     = {srem_r[AMP_W-1:0], rad_r[vad_pkg::RAD_W-1 -: 2]};
    sq_trial = {root_r, 2'b01};
    sq_ge    = (sq_t >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      rad_r      <= vad_pkg::RAD_W'(dq_r[2*AMP_W-2:0]);
      srem_r     <= '0;
      root_r     <= '0;
      sqrt_cnt_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r      <= {rad_r[vad_pkg::RAD_W-3:0], 2'b00};
      srem_r     <= sq_ge ? (sq_t - sq_trial) : sq_t;
      root_r     <= {root_r[AMP_W-2:0], sq_ge};
      sqrt_cnt_r <= sqrt_cnt_r + 1'b1;
    end
  end

  // Threshold products and the voice decision.
  always_comb begin
    rms_scaled  = vad_pkg::PROD_W'({root_r, {vad_pkg::RMS_SH{1'b0}}});
    quiet_sum   = {1'b0, quiet_r} + (QUIET_W + 1)'(n_r);
    quiet_sat   = quiet_sum[QUIET_W] ? vad_pkg::QUIET_MAX : quiet_sum[QUIET_W-1:0];
    start_voice = (root_r >= min_onset_r) && (rms_scaled >= prod_on_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_on_r  <= floor_r * onset_ratio_r;
      prod_rel_r <= floor_r * release_ratio_r;
    end
    if (cmd.decide) begin
      rise_r <= (root_r > floor_r);
      diff_r <= (root_r > floor_r) ? (root_r - floor_r) : (floor_r - root_r);
    end
    if (cmd.step_mul) begin
      step_r <= step_prod[vad_pkg::STEP_PROD_W-1:vad_pkg::COEF_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r <= 1'b0;
      quiet_r <= vad_pkg::INIT_QUIET_RST;
      onset_r <= 1'b0;
      adapt_r <= 1'b0;
    end else if (cfg_wr_en && (cfg_index == vad_pkg::REG_INIT_QUIET)) begin
      quiet_r <= cfg_wdata[QUIET_W-1:0];
    end else if (cmd.decide) begin
      onset_r <= 1'b0;
      adapt_r <= 1'b0;
      if (!voice_r) begin
        quiet_r <= quiet_sat;
        if (start_voice) begin
          voice_r <= 1'b1;
          onset_r <= (quiet_sat >= min_gap_r);
        end else begin
          adapt_r <= 1'b1;
        end
      end else if (rms_scaled < prod_rel_r) begin
        voice_r <= 1'b0;
        quiet_r <= '0;
      end
    end
  end

  // Floor moves a fixed fraction of the gap, slower upward than downward.
  always_comb begin
    step_prod   = diff_r * (rise_r ? vad_pkg::RISE_COEF : vad_pkg::FALL_COEF);
    floor_moved = rise_r ? ({1'b0, floor_r} + (AMP_W + 1)'(step_r))
                         : ({1'b0, floor_r} - (AMP_W + 1)'(step_r));
    floor_nxt   = (floor_moved[AMP_W-1:0] < vad_pkg::FLOOR_MIN) ? vad_pkg::FLOOR_MIN
                                                                : floor_moved[AMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= vad_pkg::FLOOR_RESET;
    end else if (cmd.update && adapt_r) begin
      floor_r <= floor_nxt;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onset_ratio_r   <= vad_pkg::ONSET_RATIO_RST;
      release_ratio_r <= vad_pkg::RELEASE_RATIO_RST;
      min_onset_r     <= vad_pkg::MIN_ONSET_RST;
      min_gap_r       <= vad_pkg::MIN_GAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        vad_pkg::REG_ONSET_RATIO:   onset_ratio_r   <= cfg_wdata[vad_pkg::RATIO_W-1:0];
        vad_pkg::REG_RELEASE_RATIO: release_ratio_r <= cfg_wdata[vad_pkg::RATIO_W-1:0];
        vad_pkg::REG_MIN_ONSET_RMS: min_onset_r     <= cfg_wdata[AMP_W-1:0];
        vad_pkg::REG_MIN_GAP:       min_gap_r       <= cfg_wdata[QUIET_W-1:0];
        vad_pkg::REG_INIT_QUIET: begin
          // This value only reloads the quiet count, next to the voice state.
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rms         <= root_r;
      out_noise_floor <= floor_r;
      out_voiced      <= voice_r;
      out_word_onset  <= onset_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/voice_activity_detector_top.sv */
// ----------------------------------------------------------------------------
// Voice activity detector top level
// Energy-based voice detection over blocks of audio samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_ch, one word per accepted handshake, each carrying a
// signed sample and a last flag. A block ends on a word with last set, or by
// itself at MAX_BLOCK samples. Every closed block yields one result word on
// out_ch: block RMS, noise floor after the block, voice state and word onset.
// Non-closing samples are taken one per cycle. The closing sample starts the
// block-end sequence: a one-bit-a-cycle divide of the scaled square sum by the
// sample count, a load of the square root, the root digits, then threshold
// products, decision, floor step and hand-off before the result word shows on
// out_ch. in_ch.ready is low for that span. The result sits in an output
// register; if the receiver stalls, sampling of the next block goes on and
// only the next hand-off waits for the register. Configuration is a
// write-only port (cfg_wr_en, cfg_index, cfg_wdata); the user is to write it
// only while idle, which the block itself does not enforce. Writing the
// initial quiet register also reloads the quiet count.
// A synchronous low rst_n restores register defaults, empties the block and
// the output register, clears the voice state and resets the noise floor.
// ----------------------------------------------------------------------------
module voice_activity_detector_top #(
  parameter int MAX_BLOCK = vad_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  vad_in_if.sink                         in_ch,
  vad_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [vad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vad_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  vad_pkg::vad_cmd_t cmd;
  vad_pkg::vad_sts_t sts;

  // The controller owns sequencing and the input handshake.
  vad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds all arithmetic, state and the result register.
  vad_datapath #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample          (in_ch.sample),
    .last            (in_ch.last),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_rms         (out_ch.rms),
    .out_noise_floor (out_ch.noise_floor),
    .out_voiced      (out_ch.voiced),
    .out_word_onset  (out_ch.word_onset)
  );

endmodule
